// ----- design/vndn_pkg.sv -----
// Package for the vector norm / dot / normalize unit: word types, codes and defaults.
// Used by every module of the block. It has no dependencies.
`timescale 1ns / 1ps

package vndn_pkg;

  // Default configuration values.
  localparam int VNDN_MAX_DIM   = 16;
  localparam int VNDN_FRAC_BITS = 16;

  // Fixed widths of the datapath.
  localparam int WORD_W      = 32;
  localparam int SUM_W       = 64;
  localparam int QUEUE_DEPTH = 4;

  // Run modes, taken from cmd on the first word of a run.
  localparam logic MODE_NORM = 1'b0;
  localparam logic MODE_DOT  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_LEN  = 2'd0;
  localparam logic [1:0] KIND_NORM = 2'd1;
  localparam logic [1:0] KIND_DOT  = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_ZERO    = 2'd1;
  localparam logic [1:0] ERR_DROPPED = 2'd2;

  // Input word.
  typedef struct packed {
    logic               cmd;
    logic signed [31:0] coord;
    logic signed [31:0] other_coord;
    logic               last;
  } vndn_in_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         kind;
    logic [1:0]         error;
    logic               run_end;
  } vndn_out_t;

  // Classified word passed from the front end to the back end.
  typedef struct packed {
    logic               mode;
    logic               keep;
    logic               last;
    logic               ovf;
    logic signed [31:0] coord;
    logic signed [31:0] other_coord;
  } vndn_entry_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SQRT,
    ST_LEN_OUT,
    ST_RD,
    ST_DIV_INIT,
    ST_DIV,
    ST_NORM_OUT,
    ST_DOT_OUT
  } back_state_t;

endpackage

// ----- design/vndn_front.sv -----
// Front end: accepts input words, tracks the run mode and the element count,
// and marks each word as kept or dropped. Depends on vndn_pkg.
`timescale 1ns / 1ps

module vndn_front #(
  parameter int MAX_DIM = vndn_pkg::VNDN_MAX_DIM
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  vndn_pkg::vndn_in_t    in_word,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  q_push,
  output vndn_pkg::vndn_entry_t q_entry
);
  import vndn_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             mode_r, mode_nxt;
  logic             ovf_r, ovf_nxt;
  logic             run_mode;
  logic             keep;
  logic             accept;

  // The queue being full is the only reason to hold off the source.
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // The mode is latched from the first word of a run.
  assign run_mode = (count_r == '0) ? in_word.cmd : mode_r;
  assign keep     = count_r < CNT_W'(MAX_DIM);

  // Classified word for the back end.
  always_comb begin
    q_push              = accept;
    q_entry.mode        = run_mode;
    q_entry.keep        = keep;
    q_entry.last        = in_word.last;
    q_entry.ovf         = ovf_r | ~keep;
    q_entry.coord       = in_word.coord;
    q_entry.other_coord = in_word.other_coord;
  end

  // Run bookkeeping; everything returns to zero after the last word.
  always_comb begin
    count_nxt = count_r;
    mode_nxt  = mode_r;
    ovf_nxt   = ovf_r;
    if (accept) begin
      if (in_word.last) begin
        count_nxt = '0;
        mode_nxt  = MODE_NORM;
        ovf_nxt   = 1'b0;
      end else begin
        count_nxt = keep ? count_r + CNT_W'(1) : count_r;
        mode_nxt  = run_mode;
        ovf_nxt   = ovf_r | ~keep;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      mode_r  <= MODE_NORM;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      mode_r  <= mode_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ----- design/vndn_fifo.sv -----
// Short queue of classified words between the front and back ends.
// Depends on vndn_pkg for the entry type and the depth.
`timescale 1ns / 1ps

module vndn_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  vndn_pkg::vndn_entry_t push_data,
  input  logic                  pop,
  output vndn_pkg::vndn_entry_t pop_data,
  output logic                  full,
  output logic                  empty
);
  import vndn_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  vndn_entry_t      slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;

  assign full     = fill_r == CNT_W'(QUEUE_DEPTH);
  assign empty    = fill_r == '0;
  assign pop_data = slot_r[rd_ptr_r];

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/vndn_back.sv -----
// Back end: accumulates squares or products; normalize runs then take the square root and
// the per-coordinate division on shared iterative hardware. Depends on vndn_pkg.
`timescale 1ns / 1ps

module vndn_back #(
  parameter int MAX_DIM   = vndn_pkg::VNDN_MAX_DIM,
  parameter int FRAC_BITS = vndn_pkg::VNDN_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  vndn_pkg::vndn_entry_t q_entry,
  output logic                  q_pop,
  output logic                  out_valid,
  output vndn_pkg::vndn_out_t   out_word,
  input  logic                  out_stall
);
  import vndn_pkg::*;

  localparam int CNT_W      = $clog2(MAX_DIM + 1);
  localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DVD_W      = WORD_W + FRAC_BITS;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int ITER_N     = (DVD_W > SQRT_STEPS) ? DVD_W : SQRT_STEPS;
  localparam int STEP_W     = $clog2(ITER_N);
  localparam int REM_W      = WORD_W + 2;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Saturating add of two signed 64-bit values.
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] a,
    input logic signed [SUM_W-1:0] b
  );
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      return s[SUM_W] ? SUM_MIN : SUM_MAX;
    end
    return s[SUM_W-1:0];
  endfunction

  // Sequencer and datapath registers.
  back_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic signed [SUM_W-1:0] prod_r, prod_nxt;
  logic                    prod_v_r, prod_v_nxt;
  logic                    prod_last_r, prod_last_nxt;
  logic                    last_pend_r, last_pend_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    mode_r, mode_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [REM_W-1:0]        rem_r, rem_nxt;
  logic [SUM_W-1:0]        work_r, work_nxt;
  logic [WORD_W-1:0]       len_r, len_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    neg_r, neg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  vndn_out_t               out_word_r, out_word_nxt;

  // Coordinate store.
  logic [WORD_W-1:0]       store_mem [MAX_DIM];
  logic [WORD_W-1:0]       rd_data_r;
  logic                    mem_we;
  logic                    mem_re;

  // Combinational helpers.
  logic                    out_free;
  logic signed [WORD_W-1:0] mult_b;
  logic signed [SUM_W-1:0] prod_full;
  logic signed [SUM_W-1:0] sum_acc;
  logic [REM_W-1:0]        sq_try;
  logic [REM_W-1:0]        sq_trial;
  logic                    sq_ge;
  logic [WORD_W:0]         dv_try;
  logic                    dv_ge;
  logic [WORD_W-1:0]       rd_mag;
  logic [DVD_W-1:0]        quot;
  logic [WORD_W-1:0]       norm_bits;
  logic signed [SUM_W-1:0] dot_sh;
  logic                    dot_fits;
  logic [WORD_W-1:0]       dot_bits;
  logic [WORD_W-1:0]       len_bits;
  logic [1:0]              err_norm;
  logic [1:0]              err_dot;
  logic                    idx_at_end;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Product of the popped word; squares in normalize mode.
  assign mult_b    = (q_entry.mode == MODE_DOT) ? q_entry.other_coord : q_entry.coord;
  assign prod_full = q_entry.coord * mult_b;
  assign sum_acc   = sat_add(sum_r, prod_r);

  // One square-root digit per cycle on the radicand held in work_r.
  assign sq_try   = {rem_r[REM_W-3:0], work_r[SUM_W-1 -: 2]};
  assign sq_trial = {len_r, 2'b01};
  assign sq_ge    = sq_try >= sq_trial;

  // One restoring division bit per cycle; the remainder stays below the length.
  assign dv_try = {rem_r[WORD_W-1:0], work_r[DVD_W-1]};
  assign dv_ge  = dv_try >= {1'b0, len_r};

  assign rd_mag = rd_data_r[WORD_W-1] ? (WORD_W'(0) - rd_data_r) : rd_data_r;

  // Normalized coordinate with saturation; a zero length forces zero.
  always_comb begin
    quot = (len_r == '0) ? '0 : work_r[DVD_W-1:0];
    if (neg_r && quot != '0) begin
      if (quot[DVD_W-1:WORD_W] != '0 || (quot[WORD_W-1] && quot[WORD_W-2:0] != '0)) begin
        norm_bits = WORD_MIN;
      end else begin
        norm_bits = WORD_W'(0) - quot[WORD_W-1:0];
      end
    end else if (quot[DVD_W-1:WORD_W-1] != '0) begin
      norm_bits = WORD_MAX;
    end else begin
      norm_bits = quot[WORD_W-1:0];
    end
  end

  // Dot result: floor shift, then saturate to 32 bits.
  assign dot_sh   = sum_r >>> FRAC_BITS;
  assign dot_fits = (&dot_sh[SUM_W-1:WORD_W-1]) || !(|dot_sh[SUM_W-1:WORD_W-1]);
  assign dot_bits = dot_fits ? dot_sh[WORD_W-1:0]
                             : (dot_sh[SUM_W-1] ? WORD_MIN : WORD_MAX);

  assign len_bits   = len_r[WORD_W-1] ? WORD_MAX : len_r;
  assign err_norm   = (len_r == '0) ? ERR_ZERO : (ovf_r ? ERR_DROPPED : ERR_NONE);
  assign err_dot    = ovf_r ? ERR_DROPPED : ERR_NONE;
  assign idx_at_end = (idx_r + CNT_W'(1)) == count_r;

  // Sequencer: next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    prod_v_nxt    = 1'b0;
    prod_last_nxt = prod_last_r;
    last_pend_nxt = last_pend_r;
    sum_nxt       = sum_r;
    mode_nxt      = mode_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    work_nxt      = work_r;
    len_nxt       = len_r;
    step_nxt      = step_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        // Pop stage: store the coordinate and form the product.
        if (!q_empty && !last_pend_r) begin
          q_pop         = 1'b1;
          prod_v_nxt    = 1'b1;
          prod_last_nxt = q_entry.last;
          prod_nxt      = q_entry.keep ? prod_full : '0;
          if (q_entry.keep) begin
            count_nxt = count_r + CNT_W'(1);
            mem_we    = (q_entry.mode == MODE_NORM);
          end
          if (q_entry.last) begin
            last_pend_nxt = 1'b1;
            mode_nxt      = q_entry.mode;
            ovf_nxt       = q_entry.ovf;
          end
        end
        // Accumulate stage; the last word starts the finishing work.
        if (prod_v_r) begin
          sum_nxt = sum_acc;
          if (prod_last_r) begin
            last_pend_nxt = 1'b0;
            rem_nxt       = '0;
            len_nxt       = '0;
            step_nxt      = '0;
            work_nxt      = sum_acc;
            state_nxt     = (mode_r == MODE_DOT) ? ST_DOT_OUT : ST_SQRT;
          end
        end
      end

      ST_SQRT: begin
        rem_nxt  = sq_ge ? sq_try - sq_trial : sq_try;
        len_nxt  = {len_r[WORD_W-2:0], sq_ge};
        work_nxt = {work_r[SUM_W-3:0], 2'b00};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_LEN_OUT;
        end
      end

      ST_LEN_OUT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.value   = len_bits;
          out_word_nxt.kind    = KIND_LEN;
          out_word_nxt.error   = err_norm;
          out_word_nxt.run_end = (count_r == '0);
          idx_nxt              = '0;
          if (count_r == '0) begin
            sum_nxt   = '0;
            mode_nxt  = MODE_NORM;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end

      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_DIV_INIT;
      end

      ST_DIV_INIT: begin
        neg_nxt   = rd_data_r[WORD_W-1];
        work_nxt  = SUM_W'({rd_mag, {FRAC_BITS{1'b0}}});
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        rem_nxt               = REM_W'(dv_ge ? dv_try - {1'b0, len_r} : dv_try);
        work_nxt[DVD_W-1:0]   = {work_r[DVD_W-2:0], dv_ge};
        step_nxt              = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DVD_W - 1)) begin
          state_nxt = ST_NORM_OUT;
        end
      end

      ST_NORM_OUT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.value   = norm_bits;
          out_word_nxt.kind    = KIND_NORM;
          out_word_nxt.error   = err_norm;
          out_word_nxt.run_end = idx_at_end;
          if (idx_at_end) begin
            count_nxt = '0;
            sum_nxt   = '0;
            mode_nxt  = MODE_NORM;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = ST_RD;
          end
        end
      end

      ST_DOT_OUT: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_word_nxt.value   = dot_bits;
          out_word_nxt.kind    = KIND_DOT;
          out_word_nxt.error   = err_dot;
          out_word_nxt.run_end = 1'b1;
          count_nxt            = '0;
          sum_nxt              = '0;
          mode_nxt             = MODE_NORM;
          ovf_nxt              = 1'b0;
          state_nxt            = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      idx_r       <= '0;
      prod_v_r    <= 1'b0;
      prod_last_r <= 1'b0;
      last_pend_r <= 1'b0;
      sum_r       <= '0;
      mode_r      <= MODE_NORM;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      prod_v_r    <= prod_v_nxt;
      prod_last_r <= prod_last_nxt;
      last_pend_r <= last_pend_nxt;
      sum_r       <= sum_nxt;
      mode_r      <= mode_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    rem_r      <= rem_nxt;
    work_r     <= work_nxt;
    len_r      <= len_nxt;
    step_r     <= step_nxt;
    neg_r      <= neg_nxt;
    out_word_r <= out_word_nxt;
  end

  // Coordinate store with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[count_r[IDX_W-1:0]] <= q_entry.coord;
    end
    if (mem_re) begin
      rd_data_r <= store_mem[idx_r[IDX_W-1:0]];
    end
  end

endmodule

// ----- design/vector_norm_dot_normalize_unit.sv -----
// Top level of the vector norm / dot / normalize unit.
// Connects vndn_front, vndn_fifo and vndn_back; depends on vndn_pkg.
//
//   Channel | Direction | Handshake          | Word
//   in_     | input     | in_valid/in_stall  | vndn_in_t  (cmd, coord, other_coord, last)
//   out_    | output    | out_valid/out_stall| vndn_out_t (value, kind, error, run_end)
//
// Coordinates load at one word per cycle through a four-entry queue while the queue has room.
// Normalize runs then take the square root (two radicand bits per step)
// and divide each coordinate in the bit-serial divider.
// Dot runs register the last product, add it into the sum, then load the result register.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// Output stall holds the result register; input stall rises only when the queue is full.
`timescale 1ns / 1ps

module vector_norm_dot_normalize_unit #(
  parameter int MAX_DIM   = vndn_pkg::VNDN_MAX_DIM,
  parameter int FRAC_BITS = vndn_pkg::VNDN_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  vndn_pkg::vndn_in_t  in_word,
  output logic                in_stall,
  output logic                out_valid,
  output vndn_pkg::vndn_out_t out_word,
  input  logic                out_stall
);
  import vndn_pkg::*;

  vndn_entry_t push_entry;
  vndn_entry_t pop_entry;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  // Front end: classification of incoming words.
  vndn_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_word (in_word),
    .in_stall(in_stall),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  // Queue between the two halves.
  vndn_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_entry),
    .pop      (q_pop),
    .pop_data (pop_entry),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: accumulation, square root, division and result register.
  vndn_back #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_word (out_word),
    .out_stall(out_stall)
  );

endmodule
